/* hdl/sme_pkg.sv */
// Shared types and constants for the stack machine executor.
// Opcodes, status codes, item kinds and stream widths; no dependencies.
`timescale 1ns / 1ps

package sme_pkg;

   localparam int SME_STACK_DEPTH = 1024;
   localparam int WORD_W          = 32;
   localparam int CMD_W           = 4;
   localparam int STATUS_W        = 3;
   localparam int REQ_TDATA_W     = 40;
   localparam int RSP_TDATA_W     = 40;

   localparam logic [CMD_W-1:0] OP_END   = 4'd0;
   localparam logic [CMD_W-1:0] OP_ABORT = 4'd1;
   localparam logic [CMD_W-1:0] OP_PUSH  = 4'd2;
   localparam logic [CMD_W-1:0] OP_POP   = 4'd3;
   localparam logic [CMD_W-1:0] OP_OUT   = 4'd4;
   localparam logic [CMD_W-1:0] OP_ADD   = 4'd5;
   localparam logic [CMD_W-1:0] OP_SUB   = 4'd6;
   localparam logic [CMD_W-1:0] OP_MUL   = 4'd7;
   localparam logic [CMD_W-1:0] OP_DIV   = 4'd8;
   localparam logic [CMD_W-1:0] OP_DUP   = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ENDED     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABORTED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd7;

   typedef enum logic [3:0] {
      KIND_END,
      KIND_ABORT,
      KIND_PUSH,
      KIND_POP,
      KIND_OUT,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_DUP,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [WORD_W-1:0] imm;
   } item_type;

endpackage

/* hdl/sme_front.sv */
// Front end: accepts request transfers, decodes the opcode into a kind
// and buffers items in a two-entry queue. Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sme_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           q_valid,
   output sme_pkg::item_type              q_item,
   input  logic                           q_pop
);
   import sme_pkg::*;

   item_type   slot_ff [2];
   item_type   new_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   always_comb begin
      new_item.imm = req_tdata[CMD_W +: WORD_W];
      unique case (req_tdata[CMD_W-1:0])
         OP_END:   new_item.kind = KIND_END;
         OP_ABORT: new_item.kind = KIND_ABORT;
         OP_PUSH:  new_item.kind = KIND_PUSH;
         OP_POP:   new_item.kind = KIND_POP;
         OP_OUT:   new_item.kind = KIND_OUT;
         OP_ADD:   new_item.kind = KIND_ADD;
         OP_SUB:   new_item.kind = KIND_SUB;
         OP_MUL:   new_item.kind = KIND_MUL;
         OP_DIV:   new_item.kind = KIND_DIV;
         OP_DUP:   new_item.kind = KIND_DUP;
         default:  new_item.kind = KIND_BAD;
      endcase
   end

   assign req_tready = (fill_ff != 2'd2) & ~reset;
   assign push       = req_tvalid & req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hdl/sme_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Used by the back end for the div instruction. Depends on sme_pkg.
`timescale 1ns / 1ps

module sme_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sme_pkg::WORD_W-1:0] dividend,
   input  logic [sme_pkg::WORD_W-1:0] divisor,
   output logic                      busy,
   output logic                      done,
   output logic [sme_pkg::WORD_W-1:0] quotient
);
   import sme_pkg::*;

   localparam int STEP_W = $clog2(WORD_W);

   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dsr_ff, dsr_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = ~diff[WORD_W];

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend[WORD_W-1] ? -dividend : dividend;
         dsr_in  = divisor[WORD_W-1] ? -divisor : divisor;
         neg_in  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
         quo_in  = {quo_ff[WORD_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

/* hdl/sme_back.sv */
// Back end: stack memory, top-of-stack register, execution sequencer and
// response output register. Depends on sme_pkg and sme_divider.
`timescale 1ns / 1ps

module sme_back #(
   parameter int STACK_DEPTH = sme_pkg::SME_STACK_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  sme_pkg::item_type              q_item,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sme_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sme_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   logic [WORD_W-1:0] mem [STACK_DEPTH];

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [WORD_W-1:0]      tos_ff, tos_in;
   logic                   halted_ff, halted_in;
   kind_type               kind_ff, kind_in;
   logic [WORD_W-1:0]      res_value_ff, res_value_in;
   logic                   res_valid_ff, res_valid_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [WORD_W-1:0]      rd_data_ff;

   logic [CW-1:0]     cnt_m2;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] alu_value;
   logic              full, empty;
   logic              div_start, div_busy, div_done;
   logic [WORD_W-1:0] div_quotient;

   sme_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data_ff),
      .divisor  (tos_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign cnt_m2 = count_ff - CW'(2);
   assign full   = (count_ff == CW'(STACK_DEPTH));
   assign empty  = (count_ff == '0);
   assign q_pop  = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      unique case (kind_ff)
         KIND_ADD: alu_value = rd_data_ff + tos_ff;
         KIND_SUB: alu_value = rd_data_ff - tos_ff;
         default:  alu_value = rd_data_ff * tos_ff;
      endcase
   end

   always_comb begin
      logic [STATUS_W-1:0] st;
      state_in      = state_ff;
      count_in      = count_ff;
      tos_in        = tos_ff;
      halted_in     = halted_ff;
      kind_in       = kind_ff;
      res_value_in  = res_value_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = q_item.imm;
      div_start     = 1'b0;
      st            = ST_OK;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               kind_in      = q_item.kind;
               res_value_in = '0;
               res_valid_in = 1'b0;
               state_in     = S_DONE;
               if (halted_ff) begin
                  st = ST_HALTED;
               end else begin
                  unique case (q_item.kind)
                     KIND_END:   st = ST_ENDED;
                     KIND_ABORT: st = ST_ABORTED;
                     KIND_PUSH: begin
                        if (full) begin
                           st = ST_OVERFLOW;
                        end else begin
                           wr_en    = 1'b1;
                           tos_in   = q_item.imm;
                           count_in = count_ff + CW'(1);
                        end
                     end
                     KIND_POP: begin
                        if (empty) st = ST_UNDERFLOW;
                        else       state_in = S_READ;
                     end
                     KIND_OUT: begin
                        if (empty) begin
                           st = ST_UNDERFLOW;
                        end else begin
                           res_value_in = tos_ff;
                           res_valid_in = 1'b1;
                        end
                     end
                     KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                        if (count_ff < CW'(2)) begin
                           st = ST_UNDERFLOW;
                        end else if (q_item.kind == KIND_DIV && tos_ff == '0) begin
                           st = ST_DIVZERO;
                        end else begin
                           state_in = S_READ;
                        end
                     end
                     KIND_DUP: begin
                        if (empty) begin
                           st = ST_UNDERFLOW;
                        end else if (full) begin
                           st = ST_OVERFLOW;
                        end else begin
                           wr_en    = 1'b1;
                           wr_data  = tos_ff;
                           count_in = count_ff + CW'(1);
                        end
                     end
                     KIND_BAD: st = ST_UNKNOWN;
                     default:  st = ST_UNKNOWN;
                  endcase
                  if (st != ST_OK) begin
                     halted_in = 1'b1;
                  end
               end
               res_status_in = st;
            end
         end
         S_READ: begin
            unique case (kind_ff)
               KIND_POP: begin
                  tos_in   = rd_data_ff;
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
               KIND_DIV: begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
               default: begin
                  wr_en    = 1'b1;
                  wr_addr  = cnt_m2[AW-1:0];
                  wr_data  = alu_value;
                  tos_in   = alu_value;
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[AW-1:0];
               wr_data  = div_quotient;
               tos_in   = div_quotient;
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({res_status_ff, res_valid_ff, res_value_ff});
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[cnt_m2[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      tos_ff        <= tos_in;
      kind_ff       <= kind_in;
      res_value_ff  <= res_value_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count above depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_out_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[WORD_W])
         |-> (rsp_data_ff[WORD_W+1 +: STATUS_W] == ST_OK))
      else $error("out value flagged on a failed instruction");

   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == S_DIV))
      else $error("divider running outside the divide state");

endmodule

/* hdl/stack_machine_executor.sv */
// Stack machine executor top level: front end, item queue and back end.
// Depends on sme_pkg, sme_front, sme_back and sme_divider.
//
// Each request transfer carries one instruction; each one yields exactly
// one response transfer, in order. req_tdata holds command in [3:0] and
// immediate in [35:4]; rsp_tdata holds out_value in [31:0], out_valid in
// [32] and status in [35:33]; upper bits are zero.
// The front end takes requests into a two-entry queue; the back end runs
// them against a stack of STACK_DEPTH words held in a memory with one read
// and one write port and a cached top entry.
// Back end sequence: end, abort, push, out, dup and any failing or halted
// item go from idle straight to the done state; pop, add, sub and mul pass a
// read state first (one memory read of the second entry); div then waits in a
// divide state for the 32-step bit-serial divider.
// Reset clears the stack count, the halt flag and the queue; no clearing
// pass runs, so requests are taken as soon as reset is released.
// When the receiver stalls, the response register holds, the back end
// waits with the next finished result and the queue keeps taking requests
// until it is full.
`timescale 1ns / 1ps

module stack_machine_executor #(
   parameter int STACK_DEPTH = sme_pkg::SME_STACK_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [3:0] command, [35:4] immediate, [39:36] zero
   input  logic [sme_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] out_value, [32] out_valid, [35:33] status, [39:36] zero
   output logic [sme_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sme_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   sme_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   sme_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* tb/sme_checker.sv */
// Scoreboard for the stack machine executor: predicts each response from the request stream.
// Depends on sme_pkg; watches both stream channels and reports mismatch, pending and result counts.
`timescale 1ns / 1ps

module sme_checker #(
   parameter int STACK_DEPTH = sme_pkg::SME_STACK_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [sme_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [sme_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              result_count
);
   import sme_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0]   value;
      logic                shown;
      logic [STATUS_W-1:0] status;
   } outcome_t;

   outcome_t          awaited_outcomes[$];
   logic [WORD_W-1:0] words[STACK_DEPTH];
   int unsigned       word_count;
   logic              halted;
   int                errors;
   int                checked;

   function automatic logic [WORD_W-1:0] arith(input logic [CMD_W-1:0] op,
                                               input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
      case (op)
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         default: begin
            // the most negative word over minus one wraps to itself
            if (b == '1) return -a;
            return $signed(a) / $signed(b);
         end
      endcase
   endfunction

   function automatic outcome_t execute(input logic [CMD_W-1:0] op,
                                        input logic [WORD_W-1:0] imm);
      outcome_t res;
      res.value  = '0;
      res.shown  = 1'b0;
      res.status = ST_OK;
      if (halted) begin
         res.status = ST_HALTED;
         return res;
      end
      case (op)
         OP_END:   res.status = ST_ENDED;
         OP_ABORT: res.status = ST_ABORTED;
         OP_PUSH: begin
            if (word_count >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               words[word_count] = imm;
               word_count++;
            end
         end
         OP_POP: begin
            if (word_count < 1) res.status = ST_UNDERFLOW;
            else word_count--;
         end
         OP_OUT: begin
            if (word_count < 1) begin
               res.status = ST_UNDERFLOW;
            end else begin
               res.value = words[word_count - 1];
               res.shown = 1'b1;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (word_count < 2) begin
               res.status = ST_UNDERFLOW;
            end else if (op == OP_DIV && words[word_count - 1] == '0) begin
               res.status = ST_DIVZERO;
            end else begin
               words[word_count - 2] = arith(op, words[word_count - 2], words[word_count - 1]);
               word_count--;
            end
         end
         OP_DUP: begin
            if (word_count < 1) begin
               res.status = ST_UNDERFLOW;
            end else if (word_count >= STACK_DEPTH) begin
               res.status = ST_OVERFLOW;
            end else begin
               words[word_count] = words[word_count - 1];
               word_count++;
            end
         end
         default: res.status = ST_UNKNOWN;
      endcase
      if (res.status != ST_OK) halted = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      outcome_t got;
      outcome_t want;
      if (reset) begin
         awaited_outcomes.delete();
         word_count = 0;
         halted     = 1'b0;
         errors     = 0;
         checked    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_outcomes.push_back(execute(req_tdata[CMD_W-1:0],
                                               req_tdata[CMD_W +: WORD_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value  = rsp_tdata[WORD_W-1:0];
            got.shown  = rsp_tdata[WORD_W];
            got.status = rsp_tdata[WORD_W+1 +: STATUS_W];
            checked++;
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: response transfer with none expected, actual status %0d value %h",
                        $time, got.status, got.value);
               errors++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.shown !== want.shown) begin
                  $display("%0t: out_valid mismatch, expected %0d, actual %0d",
                           $time, want.shown, got.shown);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $display("%0t: out_value mismatch, expected %h, actual %h",
                           $time, want.value, got.value);
                  errors++;
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= awaited_outcomes.size();
      result_count   <= checked;
   end

endmodule

/* tb/tb_stack_machine_executor.sv */
// Top of the stack machine executor testbench: clock, reset, instruction stimulus and verdict.
// Depends on sme_pkg, stack_machine_executor and sme_checker.
`timescale 1ns / 1ps

module tb_stack_machine_executor;
   import sme_pkg::*;

   localparam int DEPTH        = SME_STACK_DEPTH;
   localparam int RANDOM_ITEMS = 1500;
   localparam int ITEM_TARGET  = 1650;
   localparam int TAIL_ITEMS   = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 2000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int   mismatch_count;
   int   pending_count;
   int   result_count;
   logic steady     = 1'b0;
   int   hold_left  = 0;
   logic hold_done  = 1'b0;
   int   stall_cycles = 0;
   int   sent       = 0;
   int   depth_now  = 0;
   int   deepest    = 0;
   int   halted_at  = 0;
   logic [STATUS_W-1:0] halt_cause;
   logic [STATUS_W-1:0] halt_causes[6] = '{ST_ENDED, ST_ABORTED, ST_UNDERFLOW,
                                           ST_OVERFLOW, ST_DIVZERO, ST_UNKNOWN};

   stack_machine_executor #(.STACK_DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sme_checker #(.STACK_DEPTH(DEPTH)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .result_count   (result_count)
   );

   always #4 clock = ~clock;

   // receiver: random stalls, one long hold-off once the stream is well under way
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && result_count >= 360) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 36);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] imm);
      while (!steady && $urandom_range(99) < 36) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-CMD_W-WORD_W){1'b0}}, imm, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // track stack depth for instructions known to succeed
   task automatic issue(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] imm);
      send_item(op, imm);
      case (op)
         OP_PUSH, OP_DUP: depth_now++;
         OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV: depth_now--;
         default: ;
      endcase
      if (depth_now > deepest) deepest = depth_now;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return '1;
         4: return $urandom_range(16);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_binary();
      case ($urandom_range(2))
         0: return OP_ADD;
         1: return OP_SUB;
         default: return OP_MUL;
      endcase
   endfunction

   // items still needed to reach the chosen halt from the current depth
   function automatic int halt_reserve(input logic [STATUS_W-1:0] cause);
      case (cause)
         ST_OVERFLOW:  return (DEPTH - depth_now) * 8 / 7 + 6;
         ST_UNDERFLOW: return depth_now + 3;
         default:      return 3;
      endcase
   endfunction

   task automatic random_instruction(input int grow_pct);
      int                roll;
      logic [WORD_W-1:0] divisor;
      roll = $urandom_range(99);
      if (depth_now == 0 || (roll < grow_pct && depth_now < DEPTH - 2)) begin
         if (depth_now != 0 && $urandom_range(3) == 0) issue(OP_DUP, $urandom());
         else issue(OP_PUSH, pick_word());
      end else if (roll < grow_pct + 12) begin
         issue(OP_OUT, $urandom());
      end else begin
         case ($urandom_range(4))
            0: issue(OP_POP, $urandom());
            1: begin
               // push a known nonzero divisor so the machine keeps running
               divisor = pick_word();
               if (divisor == '0) divisor = 1;
               issue(OP_PUSH, divisor);
               issue(OP_DIV, $urandom());
            end
            default: begin
               if (depth_now < 2) issue(OP_PUSH, pick_word());
               else issue(pick_binary(), $urandom());
            end
         endcase
      end
   endtask

   task automatic halt_machine(input logic [STATUS_W-1:0] cause);
      case (cause)
         ST_ENDED:   send_item(OP_END, $urandom());
         ST_ABORTED: send_item(OP_ABORT, $urandom());
         ST_UNKNOWN: send_item(CMD_W'($urandom_range(OP_DUP + 1, {CMD_W{1'b1}})),
                               $urandom());
         ST_DIVZERO: begin
            if (depth_now == 0) issue(OP_PUSH, pick_word());
            issue(OP_PUSH, '0);
            send_item(OP_DIV, $urandom());
         end
         ST_UNDERFLOW: begin
            while (depth_now > 1) begin
               if ($urandom_range(3) == 0) issue(OP_POP, $urandom());
               else issue(pick_binary(), $urandom());
            end
            if (depth_now == 1 && $urandom_range(1) == 0) begin
               send_item($urandom_range(1) ? OP_DIV : pick_binary(), $urandom());
            end else begin
               if (depth_now == 1) issue(OP_POP, $urandom());
               case ($urandom_range(3))
                  0: send_item(OP_POP, $urandom());
                  1: send_item(OP_OUT, $urandom());
                  2: send_item(OP_DUP, $urandom());
                  default: send_item(pick_binary(), $urandom());
               endcase
            end
         end
         default: begin
            while (depth_now < DEPTH) begin
               if (depth_now != 0 && $urandom_range(7) == 0) issue(OP_OUT, $urandom());
               else if (depth_now != 0 && $urandom_range(3) == 0) issue(OP_DUP, $urandom());
               else issue(OP_PUSH, pick_word());
            end
            issue(OP_OUT, $urandom());
            issue(OP_POP, $urandom());
            issue(OP_PUSH, pick_word());
            send_item($urandom_range(1) ? OP_PUSH : OP_DUP, pick_word());
         end
      endcase
   endtask

   initial begin
      int grow_pct;
      int random_done;
      int segment_grow[3] = '{30, 45, 65};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wrapping arithmetic, truncating division and field extremes
      issue(OP_PUSH, 32'h7FFF_FFFF);
      issue(OP_PUSH, 32'd1);
      issue(OP_ADD, '1);
      issue(OP_OUT, '0);
      issue(OP_PUSH, '1);
      issue(OP_DIV, 32'h8000_0000);
      issue(OP_OUT, 32'h5555_5555);
      issue(OP_PUSH, -32'sd7);
      issue(OP_PUSH, 32'd2);
      issue(OP_DIV, '0);
      issue(OP_OUT, 32'hAAAA_AAAA);
      issue(OP_PUSH, 32'h8000_0000);
      issue(OP_SUB, '0);
      issue(OP_DUP, '1);
      issue(OP_MUL, '0);
      issue(OP_OUT, '0);
      issue(OP_PUSH, '0);
      issue(OP_MUL, '0);
      issue(OP_PUSH, '1);
      issue(OP_SUB, '0);
      issue(OP_OUT, '1);
      issue(OP_POP, '0);
      issue(OP_POP, '1);
      wait_drained();

      halt_cause  = halt_causes[$urandom_range(5)];
      grow_pct    = 45;
      random_done = 0;
      while (random_done < RANDOM_ITEMS &&
             sent + TAIL_ITEMS + halt_reserve(halt_cause) < ITEM_TARGET) begin
         if (random_done % 100 == 0) grow_pct = segment_grow[$urandom_range(2)];
         steady <= (random_done >= 20 && random_done < 260);
         random_instruction(grow_pct);
         random_done++;
      end
      steady <= 1'b0;

      halt_machine(halt_cause);
      halted_at = sent;
      repeat (TAIL_ITEMS) send_item(CMD_W'($urandom()), $urandom());
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Covered %0d instructions and %0d checked results; stack reached %0d of %0d.",
               sent, result_count, deepest, DEPTH);
      $display("Machine halted with status %0d, then took %0d instructions while halted.",
               halt_cause, sent - halted_at);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
